[rtl/assert_macros.svh]
// Assertion macros shared by the touch filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising clk edge, masked while arst_n is low.
`define TFSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check on every rising clk edge, reset included.
`define TFSM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFSM_ASSERT(lbl, prop, msg)
`define TFSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/tfsm_pkg.sv]
// Types, constants and register codes of the touch filter and screen mapper.
package tfsm_pkg;

	localparam int RAW_BITS      = 12;
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int RAW_MIN       = 30;
	localparam int RAW_MAX       = 4500;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 18;

	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	// Gain numerator is alpha_span * 256: 24 bits, one quotient bit per step.
	localparam int DIV_STEPS     = 24;
	localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ALPHA_FINAL = 3'd0,
		REG_ALPHA_SPAN  = 3'd1,
		REG_DECAY_RATE  = 3'd2,
		REG_SCALE_X     = 3'd3,
		REG_SCALE_Y     = 3'd4,
		REG_OFFSET_X    = 3'd5,
		REG_OFFSET_Y    = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_VALID        = 2'd0,
		ST_NO_TOUCH     = 2'd1,
		ST_RAW_RANGE    = 2'd2,
		ST_SCREEN_RANGE = 2'd3
	} status_t;

	// Touch phase of a sample, decided in the front end.
	typedef enum logic [1:0] {
		KIND_RELEASE,
		KIND_START,
		KIND_HOLD
	} kind_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DEN,
		BK_DIV,
		BK_GAIN,
		BK_EST,
		BK_MAPX,
		BK_MAPY,
		BK_MAPF,
		BK_WRITE
	} back_state_t;

	typedef struct packed {
		logic        [15:0] alpha_final;
		logic        [15:0] alpha_span;
		logic        [15:0] decay_rate;
		logic signed [17:0] scale_x;
		logic signed [17:0] scale_y;
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		alpha_final: 16'd4,
		alpha_span:  16'd23753,
		decay_rate:  16'd1331,
		scale_x:     18'sd5243,
		scale_y:     18'sd5243,
		offset_x:    16'sd0,
		offset_y:    16'sd0
	};

	// One classified sample as it waits between front and back end.
	typedef struct packed {
		kind_t               kind;
		logic [15:0]         count;
		logic [RAW_BITS-1:0] raw_x;
		logic [RAW_BITS-1:0] raw_y;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

[rtl/tfsm_if.sv]
// Handshake interfaces for sample, result and configuration words.
interface tfsm_sample_if
	import tfsm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                touch_detected;
	logic [RAW_BITS-1:0] raw_x;
	logic [RAW_BITS-1:0] raw_y;

	modport source (output valid, output touch_detected, output raw_x, output raw_y,
		input ready);
	modport sink (input valid, input touch_detected, input raw_x, input raw_y,
		output ready);
endinterface

interface tfsm_result_if
	import tfsm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic        [8:0]  screen_x;
	logic        [8:0]  screen_y;
	logic signed [15:0] filtered_x;

	modport source (output valid, output status, output screen_x, output screen_y,
		output filtered_x, input ready);
	modport sink (input valid, input status, input screen_x, input screen_y,
		input filtered_x, output ready);
endinterface

interface tfsm_cfg_if
	import tfsm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/tfsm_front.sv]
// Front end: accept samples, track the touch run and classify each sample.
module tfsm_front
	import tfsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	tfsm_sample_if.sink  sample,
	input  queue_stat_t  q_stat,
	output logic         push,
	output entry_t       push_entry
);

	logic        touch_active_q;
	logic [15:0] sample_count_q;
	logic [15:0] count_next;

	assign sample.ready = !q_stat.full;
	assign push         = sample.valid && sample.ready;

	// Saturating run length; a new touch restarts at zero.
	always_comb begin
		if (!touch_active_q)
			count_next = '0;
		else if (sample_count_q == 16'hFFFF)
			count_next = sample_count_q;
		else
			count_next = sample_count_q + 16'd1;
	end

	always_comb begin
		push_entry.raw_x = sample.raw_x;
		push_entry.raw_y = sample.raw_y;
		push_entry.count = count_next;
		if (!sample.touch_detected)
			push_entry.kind = KIND_RELEASE;
		else if (touch_active_q)
			push_entry.kind = KIND_HOLD;
		else
			push_entry.kind = KIND_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			sample_count_q <= '0;
		end else if (push) begin
			if (sample.touch_detected) begin
				sample_count_q <= count_next;
				touch_active_q <= 1'b1;
			end else begin
				touch_active_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/tfsm_queue.sv]
// Short queue of classified samples between front and back end.
module tfsm_queue
	import tfsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  entry_t      push_entry,
	input  logic        pop,
	output entry_t      head,
	output queue_stat_t stat
);

	entry_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/tfsm_back.sv]
// Back end: gain division, smoothing and screen mapping on one shared multiplier.
module tfsm_back
	import tfsm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  entry_t        head,
	input  queue_stat_t   q_stat,
	output logic          pop,
	tfsm_result_if.source result
);

	back_state_t state_q, state_d;

	logic [15:0]           n_q;
	logic [RAW_BITS-1:0]   rx_q;
	logic [RAW_BITS-1:0]   ry_q;
	logic signed [15:0]    est_q;

	logic signed [17:0]    mul_a, mul_b;
	logic signed [35:0]    prod_q;

	logic [32:0]           rem_q;
	logic [23:0]           num_q;
	logic [23:0]           quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	logic [32:0]           den;
	logic [33:0]           trial;
	logic                  qbit;
	logic [32:0]           rem_next;
	logic [16:0]           alpha;
	logic signed [17:0]    diff;
	logic signed [36:0]    acc;
	logic signed [24:0]    est_wide;
	logic signed [15:0]    est_sat;
	logic                  raw_bad;
	logic signed [20:0]    sx_q, sx_d, sy_d;

	logic [1:0]            status_q;
	logic [8:0]            scr_x_q, scr_y_q;

	logic                  res_valid_q;
	logic [1:0]            res_status_q;
	logic [8:0]            res_x_q, res_y_q;
	logic signed [15:0]    res_est_q;
	logic                  out_free;

	// Truncating divide by 65536 of coord * scale - offset * 4096.
	function automatic logic signed [20:0] map_div(input logic signed [35:0] p,
		input logic signed [15:0] off);
		logic signed [36:0] q;
		logic signed [36:0] b;
		q = 37'(p) - 37'($signed({off, 12'h000}));
		b = q[36] ? 37'sd65535 : 37'sd0;
		q = q + b;
		return q[36:16];
	endfunction

	function automatic logic [8:0] clamp9(input logic signed [20:0] v);
		if (v[20])
			return 9'd0;
		else if (v > 21'sd511)
			return 9'd511;
		else
			return v[8:0];
	endfunction

	assign out_free = !res_valid_q || result.ready;

	// Restoring divider step.
	assign den      = {1'b0, prod_q[31:0]} + 33'd256;
	assign trial    = {rem_q, num_q[23]};
	assign qbit     = (trial >= {1'b0, den});
	assign rem_next = qbit ? 33'(trial - {1'b0, den}) : trial[32:0];

	assign alpha = {1'b0, cfg.alpha_final} + {1'b0, quo_q[15:0]};
	assign diff  = $signed(18'(rx_q)) - 18'(est_q);

	// Truncate toward zero, then saturate to 16 bits.
	always_comb begin
		acc = 37'($signed({est_q, 12'h000})) + 37'(prod_q);
		if (acc[36])
			acc = acc + 37'sd4095;
		est_wide = acc[36:12];
		if (est_wide > 25'sd32767)
			est_sat = 16'sh7FFF;
		else if (est_wide < -25'sd32768)
			est_sat = 16'sh8000;
		else
			est_sat = est_wide[15:0];
	end

	assign raw_bad = (est_q > $signed(16'(RAW_MAX))) || (est_q < $signed(16'(RAW_MIN)))
		|| (17'(ry_q) > 17'(RAW_MAX)) || (17'(ry_q) < 17'(RAW_MIN));

	assign sx_d = map_div(prod_q, cfg.offset_x);
	assign sy_d = map_div(prod_q, cfg.offset_y);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					state_d = (head.kind == KIND_RELEASE) ? BK_WRITE : BK_DEN;
				end
			end
			BK_DEN: begin
				mul_a = $signed(18'(cfg.decay_rate));
				mul_b = $signed(18'(n_q));
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1))
					state_d = BK_GAIN;
			end
			BK_GAIN: begin
				mul_a = $signed(18'(alpha));
				mul_b = diff;
				state_d = BK_EST;
			end
			BK_EST: begin
				state_d = BK_MAPX;
			end
			BK_MAPX: begin
				mul_a = 18'(est_q);
				mul_b = cfg.scale_x;
				state_d = raw_bad ? BK_WRITE : BK_MAPY;
			end
			BK_MAPY: begin
				mul_a = $signed(18'(ry_q));
				mul_b = cfg.scale_y;
				state_d = BK_MAPF;
			end
			BK_MAPF: begin
				state_d = BK_WRITE;
			end
			BK_WRITE: begin
				if (out_free)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			est_q <= '0;
		else if (state_q == BK_IDLE && pop && head.kind == KIND_START)
			est_q <= '0;
		else if (state_q == BK_EST)
			est_q <= est_sat;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_DEN, BK_GAIN, BK_MAPX, BK_MAPY: prod_q <= mul_a * mul_b;
			default: prod_q <= prod_q;
		endcase
		unique case (state_q)
			BK_IDLE: begin
				n_q      <= head.count;
				rx_q     <= head.raw_x;
				ry_q     <= head.raw_y;
				status_q <= ST_NO_TOUCH;
				scr_x_q  <= '0;
				scr_y_q  <= '0;
			end
			BK_DEN: begin
				rem_q <= '0;
				num_q <= {cfg.alpha_span, 8'h00};
				quo_q <= '0;
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= rem_next;
				num_q <= {num_q[22:0], 1'b0};
				quo_q <= {quo_q[22:0], qbit};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_MAPX: begin
				status_q <= ST_RAW_RANGE;
				scr_x_q  <= '0;
				scr_y_q  <= '0;
			end
			BK_MAPY: begin
				sx_q <= sx_d;
			end
			BK_MAPF: begin
				if (sx_q[20] || sx_q > $signed(21'(SCREEN_WIDTH))
					|| sy_d[20] || sy_d > $signed(21'(SCREEN_HEIGHT)))
					status_q <= ST_SCREEN_RANGE;
				else
					status_q <= ST_VALID;
				scr_x_q <= clamp9(sx_q);
				scr_y_q <= clamp9(sy_d);
			end
			default: ;
		endcase
	end

	// Output register: hold the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == BK_WRITE && out_free)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_WRITE && out_free) begin
			res_status_q <= status_q;
			res_x_q      <= scr_x_q;
			res_y_q      <= scr_y_q;
			res_est_q    <= est_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.status     = res_status_q;
	assign result.screen_x   = res_x_q;
	assign result.screen_y   = res_y_q;
	assign result.filtered_x = res_est_q;

endmodule

[rtl/touch_filter_and_screen_mapper_unit.sv]
// Top level of the touch filter and screen mapper: config registers and wiring.
// A touched sample runs the back end states from DEN to WRITE; a released sample goes
// straight to WRITE; a touched sample with raw coordinates out of range skips from
// MAPX to WRITE. The back end pops a new sample only once the last is written; its
// 24-step radix-2 gain divider shares the back end's single 18x18 multiplier.
// Reset: arst_n clears the touch run, the estimate, the queue and the output word,
// and returns all configuration registers to their defaults.
`include "assert_macros.svh"

module touch_filter_and_screen_mapper_unit
	import tfsm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	tfsm_sample_if.sink   sample,
	tfsm_result_if.source result,
	tfsm_cfg_if.sink      cfg
);

	cfg_t        cfg_q;
	logic        q_push;
	logic        q_pop;
	entry_t      q_in;
	entry_t      q_head;
	queue_stat_t q_stat;

	// Configuration writes are always accepted and registered; writes past the list are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ALPHA_FINAL: cfg_q.alpha_final <= cfg.data[15:0];
				REG_ALPHA_SPAN:  cfg_q.alpha_span  <= cfg.data[15:0];
				REG_DECAY_RATE:  cfg_q.decay_rate  <= cfg.data[15:0];
				REG_SCALE_X:     cfg_q.scale_x     <= $signed(cfg.data[17:0]);
				REG_SCALE_Y:     cfg_q.scale_y     <= $signed(cfg.data[17:0]);
				REG_OFFSET_X:    cfg_q.offset_x    <= $signed(cfg.data[15:0]);
				REG_OFFSET_Y:    cfg_q.offset_y    <= $signed(cfg.data[15:0]);
				default: ;
			endcase
		end
	end

	// Front end: accept and classify the sample, keep the touch run length.
	tfsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.q_stat     (q_stat),
		.push       (q_push),
		.push_entry (q_in)
	);

	// Decoupling queue so the sample port keeps flowing while the back end divides.
	tfsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// Back end: gain, smoothing, range checks and mapping, then the output word.
	tfsm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (q_head),
		.q_stat (q_stat),
		.pop    (q_pop),
		.result (result)
	);

	`TFSM_ASSERT(a_push_not_full, q_push |-> !q_stat.full, "sample pushed into a full queue")
	`TFSM_ASSERT(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from an empty queue")
	`TFSM_ASSERT(a_zero_screen, result.valid && (result.status == ST_NO_TOUCH || result.status == ST_RAW_RANGE) |-> result.screen_x == 9'd0 && result.screen_y == 9'd0, "screen coordinates not zero for a rejected sample")
	`TFSM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result.valid && q_stat.empty, "output or queue not cleared in reset")

endmodule
